// ===== sv/i2c_register_read_write_master_defines.svh =====
// Assertion macros shared by the checker of the I2C register access master.
// No dependencies; include by bare file name.
`ifndef I2C_REGISTER_READ_WRITE_MASTER_DEFINES_SVH
`define I2C_REGISTER_READ_WRITE_MASTER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CHK_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2crw_pkg.sv =====
// Package for the I2C register access master: bus operation codes, step codes,
// request and register indexes, and the decoded-step struct. No dependencies.
package i2crw_pkg;

    localparam int BURST_BYTES = 4;
    localparam int BYTE_IDX_W  = $clog2(BURST_BYTES);

    localparam logic [2:0] OP_START1 = 3'd0;
    localparam logic [2:0] OP_STARTR = 3'd1;
    localparam logic [2:0] OP_SEND   = 3'd2;
    localparam logic [2:0] OP_ACKCHK = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_MACK   = 3'd5;
    localparam logic [2:0] OP_MNACK  = 3'd6;
    localparam logic [2:0] OP_STOP   = 3'd7;

    localparam logic [4:0] STEP_START  = 5'd0;
    localparam logic [4:0] STEP_WADDR  = 5'd1;
    localparam logic [4:0] STEP_ACK1   = 5'd2;
    localparam logic [4:0] STEP_REG    = 5'd3;
    localparam logic [4:0] STEP_ACK2   = 5'd4;
    localparam logic [4:0] STEP_WDATA  = 5'd5;
    localparam logic [4:0] STEP_RSTART = 5'd5;
    localparam logic [4:0] STEP_WNACK  = 5'd6;
    localparam logic [4:0] STEP_RADDR  = 5'd6;
    localparam logic [4:0] STEP_ACK3   = 5'd7;
    localparam logic [4:0] STEP_READ   = 5'd8;
    localparam logic [4:0] STEP_RACK   = 5'd9;

    localparam logic [4:0] PHASE_IDLE  = 5'd0;
    localparam logic [4:0] PHASE_FIRST = STEP_START + 5'd1;
    localparam logic [4:0] PHASE_READ  = STEP_READ + 5'd1;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_POS   = 2'd3;

    localparam logic [1:0] CFG_WADDR  = 2'd0;
    localparam logic [1:0] CFG_RADDR  = 2'd1;
    localparam logic [1:0] CFG_POSREG = 2'd2;
    localparam logic [1:0] CFG_HALF   = 2'd3;

    localparam logic [4:0] HALVES_BYTE  = 5'd16;
    localparam logic [4:0] HALVES_THREE = 5'd3;
    localparam logic [4:0] HALVES_TWO   = 5'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic [4:0] halves;
    } op_info_t;

endpackage

// ===== sv/i2crw_op_decode.sv =====
// Step decoder of the I2C register access master: maps phase and transaction
// kind to the bus operation, its outgoing byte and its length. Uses i2crw_pkg.
module i2crw_op_decode (
    input  logic [4:0]                      phase,
    input  logic [1:0]                      kind,
    input  logic [i2crw_pkg::BYTE_IDX_W-1:0] byte_index,
    input  logic [7:0]                      write_addr,
    input  logic [7:0]                      read_addr,
    input  logic [7:0]                      latched_reg,
    input  logic [7:0]                      latched_data,
    output i2crw_pkg::op_info_t             info
);
    import i2crw_pkg::*;

    logic [4:0] step;
    logic       last_byte;

    assign step      = phase - 5'd1;
    assign last_byte = ({1'b0, byte_index} + 1'b1) >= (BYTE_IDX_W + 1)'(BURST_BYTES);

    always_comb begin
        info.op      = OP_STOP;
        info.tx_byte = 8'd0;
        if (kind == REQ_WRITE) begin
            unique case (step)
                STEP_START: info.op = OP_START1;
                STEP_WADDR: begin
                    info.op      = OP_SEND;
                    info.tx_byte = write_addr;
                end
                STEP_ACK1:  info.op = OP_ACKCHK;
                STEP_REG: begin
                    info.op      = OP_SEND;
                    info.tx_byte = latched_reg;
                end
                STEP_ACK2:  info.op = OP_ACKCHK;
                STEP_WDATA: begin
                    info.op      = OP_SEND;
                    info.tx_byte = latched_data;
                end
                STEP_WNACK: info.op = OP_MNACK;
                default:    info.op = OP_STOP;
            endcase
        end else begin
            unique case (step)
                STEP_START: info.op = OP_START1;
                STEP_WADDR: begin
                    info.op      = OP_SEND;
                    info.tx_byte = write_addr;
                end
                STEP_ACK1:   info.op = OP_ACKCHK;
                STEP_REG: begin
                    info.op      = OP_SEND;
                    info.tx_byte = latched_reg;
                end
                STEP_ACK2:   info.op = OP_ACKCHK;
                STEP_RSTART: info.op = OP_STARTR;
                STEP_RADDR: begin
                    info.op      = OP_SEND;
                    info.tx_byte = read_addr;
                end
                STEP_ACK3:   info.op = OP_ACKCHK;
                STEP_READ:   info.op = OP_READ;
                STEP_RACK:   info.op = (kind == REQ_POS && !last_byte) ? OP_MACK : OP_MNACK;
                default:     info.op = OP_STOP;
            endcase
        end

        case (info.op)
            OP_SEND, OP_READ:  info.halves = HALVES_BYTE;
            OP_STARTR, OP_STOP: info.halves = HALVES_THREE;
            default:           info.halves = HALVES_TWO;
        endcase
    end

endmodule

// ===== sv/i2c_register_read_write_master.sv =====
// I2C register access master, one bus tick per item. Uses i2crw_pkg, i2crw_op_decode.
// The result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless m_ready stalls the output; the single-pass
// tick logic sits between the sequencer state and the result register, which also
// lets the next item in. Reset (aresetn low, synchronous): idle phase, config at
// defaults, held results zero, no result pending.
module i2c_register_read_write_master (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_reg_addr,
    input  logic [7:0]  s_write_data,
    input  logic        s_sda_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_pull_low,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_read_byte,
    output logic [11:0] m_x_position,
    output logic [11:0] m_y_position,
    output logic        m_ack_missing
);
    import i2crw_pkg::*;

    logic [7:0] waddr_reg, raddr_reg, posreg_reg, half_reg;

    logic [4:0]            phase_reg, phase_next;
    logic [7:0]            tick_reg, tick_next;
    logic [3:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [BYTE_IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic [1:0]            kind_reg, kind_next;
    logic [7:0]            lreg_reg, lreg_next;
    logic [7:0]            ldata_reg, ldata_next;
    logic [7:0]            burst_reg [BURST_BYTES];
    logic [7:0]            burst_next [BURST_BYTES];
    logic                  ack_reg, ack_next;
    logic [7:0]            held_read_reg, held_read_next;
    logic [11:0]           held_x_reg, held_x_next;
    logic [11:0]           held_y_reg, held_y_next;

    logic m_valid_reg, scl_reg, pull_reg, done_reg;
    logic scl_next, pull_next, done_next;

    logic       s_accept;
    op_info_t   info;
    logic [7:0] half_len;
    logic [4:0] hi_inc;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    i2crw_op_decode u_decode (
        .phase        (phase_reg),
        .kind         (kind_reg),
        .byte_index   (byte_idx_reg),
        .write_addr   (waddr_reg),
        .read_addr    (raddr_reg),
        .latched_reg  (lreg_reg),
        .latched_data (ldata_reg),
        .info         (info)
    );

    assign half_len = (half_reg == 8'd0) ? 8'd1 : half_reg;
    assign hi_inc   = {1'b0, bit_reg} + 5'd1;

    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        byte_idx_next  = byte_idx_reg;
        kind_next      = kind_reg;
        lreg_next      = lreg_reg;
        ldata_next     = ldata_reg;
        burst_next     = burst_reg;
        ack_next       = ack_reg;
        held_read_next = held_read_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        scl_next       = 1'b1;
        pull_next      = 1'b0;
        done_next      = 1'b0;

        if (phase_reg == PHASE_IDLE) begin
            if (s_req_type != REQ_NONE) begin
                kind_next     = s_req_type;
                lreg_next     = (s_req_type == REQ_POS) ? posreg_reg : s_reg_addr;
                ldata_next    = s_write_data;
                phase_next    = PHASE_FIRST;
                tick_next     = 8'd0;
                bit_next      = 4'd0;
                shift_next    = 8'd0;
                byte_idx_next = '0;
                ack_next      = 1'b0;
                for (int i = 0; i < BURST_BYTES; i++) begin
                    burst_next[i] = 8'd0;
                end
            end
        end else begin
            case (info.op)
                OP_START1: begin
                    scl_next  = 1'b1;
                    pull_next = (bit_reg != 4'd0);
                end
                OP_STARTR: begin
                    scl_next  = (bit_reg != 4'd0);
                    pull_next = (bit_reg == 4'd2);
                end
                OP_SEND: begin
                    scl_next  = bit_reg[0];
                    pull_next = !info.tx_byte[~bit_reg[3:1]];
                end
                OP_MACK: begin
                    scl_next  = bit_reg[0];
                    pull_next = 1'b1;
                end
                OP_STOP: begin
                    scl_next  = (bit_reg != 4'd0);
                    pull_next = (bit_reg != 4'd2);
                end
                default: begin
                    scl_next  = bit_reg[0];
                    pull_next = 1'b0;
                end
            endcase

            if (({1'b0, tick_reg} + 9'd1) < {1'b0, half_len}) begin
                tick_next = tick_reg + 8'd1;
            end else begin
                tick_next = 8'd0;
                if (bit_reg[0]) begin
                    if (info.op == OP_READ) begin
                        shift_next = {shift_reg[6:0], s_sda_in};
                    end else if (info.op == OP_ACKCHK && s_sda_in) begin
                        ack_next = 1'b1;
                    end
                end
                if (hi_inc < info.halves) begin
                    bit_next = hi_inc[3:0];
                end else begin
                    bit_next = 4'd0;
                    if (info.op == OP_READ) begin
                        burst_next[byte_idx_reg] = shift_next;
                        phase_next = phase_reg + 5'd1;
                    end else if (info.op == OP_MACK) begin
                        if (byte_idx_reg != BYTE_IDX_W'(BURST_BYTES - 1)) begin
                            byte_idx_next = byte_idx_reg + 1'b1;
                        end
                        shift_next = 8'd0;
                        phase_next = PHASE_READ;
                    end else if (info.op == OP_STOP) begin
                        done_next = 1'b1;
                        if (kind_reg == REQ_READ) begin
                            held_read_next = shift_reg;
                        end
                        if (kind_reg == REQ_POS) begin
                            held_x_next = {burst_reg[0][3:0], burst_reg[1]};
                            held_y_next = (BURST_BYTES >= 4)
                                ? {burst_reg[2][3:0], burst_reg[3]} : 12'd0;
                        end
                        phase_next = PHASE_IDLE;
                    end else begin
                        phase_next = phase_reg + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waddr_reg     <= 8'd42;
            raddr_reg     <= 8'd43;
            posreg_reg    <= 8'd3;
            half_reg      <= 8'd8;
            phase_reg     <= PHASE_IDLE;
            tick_reg      <= 8'd0;
            bit_reg       <= 4'd0;
            shift_reg     <= 8'd0;
            byte_idx_reg  <= '0;
            kind_reg      <= REQ_NONE;
            lreg_reg      <= 8'd0;
            ldata_reg     <= 8'd0;
            ack_reg       <= 1'b0;
            held_read_reg <= 8'd0;
            held_x_reg    <= 12'd0;
            held_y_reg    <= 12'd0;
            for (int i = 0; i < BURST_BYTES; i++) begin
                burst_reg[i] <= 8'd0;
            end
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_WADDR:  waddr_reg  <= cfg_wdata;
                    CFG_RADDR:  raddr_reg  <= cfg_wdata;
                    CFG_POSREG: posreg_reg <= cfg_wdata;
                    CFG_HALF:   half_reg   <= cfg_wdata;
                    default:    half_reg   <= half_reg;
                endcase
            end
            if (s_accept) begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                byte_idx_reg  <= byte_idx_next;
                kind_reg      <= kind_next;
                lreg_reg      <= lreg_next;
                ldata_reg     <= ldata_next;
                burst_reg     <= burst_next;
                ack_reg       <= ack_next;
                held_read_reg <= held_read_next;
                held_x_reg    <= held_x_next;
                held_y_reg    <= held_y_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_reg  <= 1'b1;
            pull_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (s_accept) begin
            scl_reg  <= scl_next;
            pull_reg <= pull_next;
            done_reg <= done_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_scl_level    = scl_reg;
    assign m_sda_pull_low = pull_reg;
    assign m_done_res     = done_reg;
    assign m_busy_res     = (phase_reg != PHASE_IDLE);
    assign m_read_byte    = held_read_reg;
    assign m_x_position   = held_x_reg;
    assign m_y_position   = held_y_reg;
    assign m_ack_missing  = ack_reg;

endmodule

// ===== sv/i2crw_checker.sv =====
// Port-level checker for the I2C register access master, bound to the top level.
// Depends on i2c_register_read_write_master_defines.svh.
`include "i2c_register_read_write_master_defines.svh"

module i2crw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_scl_level,
    input logic        m_sda_pull_low,
    input logic        m_busy_res,
    input logic        m_done_res,
    input logic [7:0]  m_read_byte
);

    `CHK_IMPLY(a_done_ends_busy, aclk, aresetn, m_valid && m_done_res, !m_busy_res,
               "done while busy")

    `CHK_IMPLY(a_idle_levels, aclk, aresetn, m_valid && !m_busy_res,
               m_scl_level && !m_sda_pull_low, "bus not released while idle")

    `CHK_IMPLY(a_start_levels, aclk, aresetn, m_valid && m_busy_res && !$past(m_busy_res),
               m_scl_level && !m_sda_pull_low, "start tick drove the bus")

    `CHK_IMPLY(a_read_byte_hold, aclk, aresetn, !m_done_res,
               m_read_byte == $past(m_read_byte), "read byte changed without done")

    `CHK_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
              m_valid && $stable(m_scl_level) && $stable(m_sda_pull_low),
              "stalled item changed")

endmodule

bind i2c_register_read_write_master i2crw_checker u_i2crw_checker (.*);
